[rtl/core/tshd_pkg.sv]
// ----------------------------------------------------------------------------
// Stability hold with dead zone: shared package
// Register codes, field widths, reset values and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tshd_pkg;

    localparam int WINDOW_DEF      = 15;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int AXES       = 3;
    localparam int OFFSET_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int THR_W      = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 3'd7;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
    localparam logic [THR_W-1:0]  THR_RESET  = 23'd128;
    localparam logic [THR_W-1:0]  DB_RESET   = 23'd102;

    typedef struct packed {
        logic capture;
        logic wr;
        logic scan_rd;
        logic scan_first;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic filled;
        logic wrap;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

[rtl/core/tshd_ctrl.sv]
// ----------------------------------------------------------------------------
// Stability hold with dead zone: controller
// Steps one item through calibration, the ring write, the window scan once the ring is
// full and the final decision, which it loads only once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tshd_ctrl #(
    parameter int WINDOW = tshd_pkg::WINDOW_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire tshd_pkg::t_stat            i_stat,
    output tshd_pkg::t_cmd                  o_cmd,
    output logic [$clog2(WINDOW)-1:0]       o_rd_addr
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] CNT_LAST = AW'(WINDOW - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SAT   = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_rd_addr  = r_cnt;

    always_comb begin
        o_cmd.capture    = i_in_valid && (r_state == S_IDLE);
        o_cmd.wr         = (r_state == S_WRITE);
        o_cmd.scan_rd    = (r_state == S_SCAN);
        o_cmd.scan_first = (r_state == S_SCAN) && (r_cnt == '0);
        o_cmd.load       = (r_state == S_DONE) && !i_stat.out_busy;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIFF;
            end
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_SAT;
            S_SAT:   n_state = S_WRITE;
            S_WRITE: begin
                n_state = (i_stat.filled || i_stat.wrap) ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tshd_dpath.sv]
// ----------------------------------------------------------------------------
// Stability hold with dead zone: datapath
// Configuration registers, per-axis calibration, the sample ring, the
// min/max scan, the dead zone, the hold logic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tshd_dpath #(
    parameter int WINDOW      = tshd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tshd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tshd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tshd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [3*SAMPLE_BITS-1:0]          i_sample,
    input  wire tshd_pkg::t_cmd                    i_cmd,
    input  wire logic [$clog2(WINDOW)-1:0]         i_rd_addr,
    output tshd_pkg::t_stat                        o_stat,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [3*SAMPLE_BITS-1:0]               o_out_data,
    output logic [1:0]                             o_out_flags
);

    localparam int AW  = $clog2(WINDOW);
    localparam int SB  = SAMPLE_BITS;
    localparam int NAX = tshd_pkg::AXES;
    localparam int OW  = tshd_pkg::OFFSET_W;
    localparam int GW  = tshd_pkg::GAIN_W;
    localparam int TW  = tshd_pkg::THR_W;
    localparam int DW  = ((SB > OW) ? SB : OW) + 1;
    localparam int PW  = DW + GW + 1;
    localparam int CW  = ((SB + 1) > TW) ? (SB + 1) : TW;
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    logic signed [OW-1:0] r_off  [NAX];
    logic [GW-1:0]        r_gain [NAX];
    logic [TW-1:0]        r_thr;
    logic [TW-1:0]        r_db;

    logic signed [SB-1:0] r_raw  [NAX];
    logic signed [DW-1:0] r_diff [NAX];
    logic signed [PW-1:0] r_prod [NAX];
    logic signed [SB-1:0] r_cal  [NAX];
    logic signed [SB-1:0] n_cal  [NAX];

    logic [3*SB-1:0]      r_mem [WINDOW];
    logic [3*SB-1:0]      r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_first;
    logic signed [SB-1:0] r_min [NAX];
    logic signed [SB-1:0] r_max [NAX];

    logic [AW-1:0]        r_slot;
    logic                 r_filled;
    logic                 r_hold;
    logic signed [SB-1:0] r_frz [NAX];

    logic                 r_out_vld;
    logic [3*SB-1:0]      r_out_data;
    logic [1:0]           r_out_flags;

    logic signed [PW-1:0] w_q     [NAX];
    logic signed [SB-1:0] w_rd    [NAX];
    logic signed [SB:0]   w_range [NAX];
    logic [SB:0]          w_mag   [NAX];
    logic signed [SB-1:0] w_dz    [NAX];
    logic [NAX-1:0]       w_rng_ok;
    logic                 w_still;
    logic [3*SB-1:0]      w_live;
    logic [3*SB-1:0]      w_frz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NAX; a++) begin
                r_off[a]  <= '0;
                r_gain[a] <= tshd_pkg::GAIN_RESET;
            end
            r_thr <= tshd_pkg::THR_RESET;
            r_db  <= tshd_pkg::DB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tshd_pkg::REG_OFFSET_X:  r_off[0]  <= i_cfg_data[OW-1:0];
                tshd_pkg::REG_OFFSET_Y:  r_off[1]  <= i_cfg_data[OW-1:0];
                tshd_pkg::REG_OFFSET_Z:  r_off[2]  <= i_cfg_data[OW-1:0];
                tshd_pkg::REG_GAIN_X:    r_gain[0] <= i_cfg_data[GW-1:0];
                tshd_pkg::REG_GAIN_Y:    r_gain[1] <= i_cfg_data[GW-1:0];
                tshd_pkg::REG_GAIN_Z:    r_gain[2] <= i_cfg_data[GW-1:0];
                tshd_pkg::REG_THRESHOLD: r_thr     <= i_cfg_data[TW-1:0];
                tshd_pkg::REG_DEAD_BAND: r_db      <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // The calibration stages run freely; the controller waits them out.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NAX; a++) begin
            if (i_cmd.capture) r_raw[a] <= i_sample[a*SB +: SB];
            r_diff[a] <= DW'(r_raw[a]) - DW'(r_off[a]);
            r_prod[a] <= PW'(r_diff[a]) * PW'($signed({1'b0, r_gain[a]}));
            r_cal[a]  <= n_cal[a];
        end
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            w_q[a] = r_prod[a] >>> tshd_pkg::GAIN_FRAC;
            if (w_q[a] < SAT_LO) begin
                n_cal[a] = SAT_LO[SB-1:0];
            end else if (w_q[a] > SAT_HI) begin
                n_cal[a] = SAT_HI[SB-1:0];
            end else begin
                n_cal[a] = w_q[a][SB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) r_mem[r_slot] <= {r_cal[2], r_cal[1], r_cal[0]};
        if (i_cmd.scan_rd) r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.scan_rd;
            r_rd_first <= i_cmd.scan_first;
        end
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            w_rd[a] = r_rd_data[a*SB +: SB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            for (int a = 0; a < NAX; a++) begin
                if (r_rd_first || (w_rd[a] < r_min[a])) r_min[a] <= w_rd[a];
                if (r_rd_first || (w_rd[a] > r_max[a])) r_max[a] <= w_rd[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            w_range[a]  = (SB+1)'(r_max[a]) - (SB+1)'(r_min[a]);
            w_rng_ok[a] = CW'($unsigned(w_range[a])) < CW'(r_thr);
            w_mag[a]    = r_cal[a][SB-1] ? -(SB+1)'(r_cal[a]) : (SB+1)'(r_cal[a]);
            w_dz[a]     = (CW'(w_mag[a]) < CW'(r_db)) ? '0 : r_cal[a];
        end
        w_still = r_filled && (&w_rng_ok);
        w_live  = {w_dz[2], w_dz[1], w_dz[0]};
        w_frz   = {r_frz[2], r_frz[1], r_frz[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_hold   <= 1'b0;
        end else if (i_cfg_we) begin
            r_filled <= 1'b0;
            r_hold   <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                if (r_slot == SLOT_LAST) begin
                    r_slot   <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_slot <= r_slot + AW'(1);
                end
            end
            if (i_cmd.load) r_hold <= w_still;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (w_still && !r_hold) begin
                for (int a = 0; a < NAX; a++) begin
                    r_frz[a] <= w_dz[a];
                end
            end
            r_out_data  <= (w_still && r_hold) ? w_frz : w_live;
            r_out_flags <= {r_filled, w_still};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_comb begin
        o_stat.filled   = r_filled;
        o_stat.wrap     = (r_slot == SLOT_LAST);
        o_stat.out_busy = r_out_vld && !i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_out_flags = r_out_flags;

endmodule

`default_nettype wire

[rtl/core/three_axis_stability_hold_deadzone_top.sv]
// Each item is taken through calibration and the ring write and, once the ring is full,
// through a window scan that reads one ring entry a cycle; one item is in work at a time.
// The next item is accepted while a finished result waits in the output register.
// Reset (synchronous, active low) clears control state and loads register defaults;
// the ring contents are not cleared and are read only after every slot is written.
// ----------------------------------------------------------------------------
// Stability hold with dead zone: top level
// Calibrates three-axis samples, tracks a window of recent values per axis
// and freezes the dead-zoned output while all axes stay within a range.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_stability_hold_deadzone_top #(
    parameter int WINDOW      = tshd_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tshd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tshd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [tshd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // sample_x, sample_y, sample_z
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // out_x, out_y, out_z
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]         o_m_axis_tdata,
    // still_flag, window_full
    output logic [1:0]                                 o_m_axis_tuser
);

    localparam int TDW = ((3*SAMPLE_BITS+7)/8)*8;

    tshd_pkg::t_cmd              w_cmd;
    tshd_pkg::t_stat             w_stat;
    logic [$clog2(WINDOW)-1:0]   w_rd_addr;
    logic [3*SAMPLE_BITS-1:0]    w_out_data;

    tshd_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    tshd_dpath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_axis_tdata[3*SAMPLE_BITS-1:0]),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .o_stat      (w_stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (w_out_data),
        .o_out_flags (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = TDW'(w_out_data);

    a_still_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tuser[1])
        else $error("still flag without a full window");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item accepted while one is in work");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("result loaded over a waiting result");

    a_scan_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_rd |-> w_stat.filled)
        else $error("window scan before the ring is full");

endmodule

`default_nettype wire

[tb/sv/tb_three_axis_stability_hold_deadzone_top.sv]
// ----------------------------------------------------------------------------
// Stability hold with dead zone: regression testbench
// Drives raw three-axis samples into the stream input and checks every output
// item against a cycle-free predictor of calibration, saturation, dead zone,
// window range detection and the freeze of held values. Calibration registers
// are reloaded between phases while the block is idle, and both stream sides
// idle at random, with one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_three_axis_stability_hold_deadzone_top;

    localparam int WIN          = tshd_pkg::WINDOW_DEF;
    localparam int SB           = tshd_pkg::SAMPLE_BITS_DEF;
    localparam int DW           = ((3 * SB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * WIN + 12;
    localparam int HOLD_CYCLES  = 400;
    localparam longint SMAX     = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SMIN     = -(64'sd1 <<< (SB - 1));

    typedef struct packed {
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [SB-1:0] z;
        logic          still;
        logic          full;
    } t_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [tshd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [tshd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [DW-1:0]                   i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [DW-1:0]                   o_m_axis_tdata;
    logic [1:0]                      o_m_axis_tuser;

    three_axis_stability_hold_deadzone_top #(
        .WINDOW      (WIN),
        .SAMPLE_BITS (SB)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor copy of registers and state.
    logic signed [tshd_pkg::OFFSET_W-1:0] cal_off [3];
    logic [tshd_pkg::GAIN_W-1:0]          cal_gain [3];
    logic [tshd_pkg::THR_W-1:0]           cal_thr;
    logic [tshd_pkg::THR_W-1:0]           cal_db;
    longint                               hist [3][WIN];
    int                                   hist_slot;
    bit                                   hist_filled;
    bit                                   hold_active;
    longint                               frozen [3];

    t_res dz_out_q [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    bit   src_idle_en = 1'b1;
    bit   snk_idle_en = 1'b1;
    bit   hold_off_req = 1'b0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SB-1:0] clamp_sample(longint v);
        if (v > SMAX) v = SMAX;
        if (v < SMIN) v = SMIN;
        return v[SB-1:0];
    endfunction

    function automatic longint calibrate_axis(logic signed [SB-1:0] raw,
                                              logic signed [tshd_pkg::OFFSET_W-1:0] off,
                                              logic [tshd_pkg::GAIN_W-1:0] g);
        longint q;
        q = ((longint'(raw) - longint'(off)) * longint'(g)) >>> tshd_pkg::GAIN_FRAC;
        if (q > SMAX) q = SMAX;
        if (q < SMIN) q = SMIN;
        return q;
    endfunction

    function automatic longint apply_dead_band(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        return (mag < longint'(cal_db)) ? 64'sd0 : v;
    endfunction

    function automatic t_res predict_hold_output(logic signed [SB-1:0] sx,
                                                 logic signed [SB-1:0] sy,
                                                 logic signed [SB-1:0] sz);
        longint cal [3];
        longint outv [3];
        longint mn, mx;
        bit     still;
        t_res   r;
        cal[0] = calibrate_axis(sx, cal_off[0], cal_gain[0]);
        cal[1] = calibrate_axis(sy, cal_off[1], cal_gain[1]);
        cal[2] = calibrate_axis(sz, cal_off[2], cal_gain[2]);
        for (int a = 0; a < 3; a++) hist[a][hist_slot] = cal[a];
        hist_slot++;
        if (hist_slot >= WIN) begin
            hist_slot = 0;
            hist_filled = 1'b1;
        end
        still = hist_filled;
        if (hist_filled) begin
            for (int a = 0; a < 3; a++) begin
                mn = hist[a][0];
                mx = hist[a][0];
                for (int i = 1; i < WIN; i++) begin
                    if (hist[a][i] < mn) mn = hist[a][i];
                    if (hist[a][i] > mx) mx = hist[a][i];
                end
                if ((mx - mn) >= longint'(cal_thr)) still = 1'b0;
            end
        end
        if (still) begin
            if (!hold_active) begin
                for (int a = 0; a < 3; a++) frozen[a] = apply_dead_band(cal[a]);
                hold_active = 1'b1;
            end
            for (int a = 0; a < 3; a++) outv[a] = frozen[a];
        end else begin
            hold_active = 1'b0;
            for (int a = 0; a < 3; a++) outv[a] = apply_dead_band(cal[a]);
        end
        r.x     = outv[0][SB-1:0];
        r.y     = outv[1][SB-1:0];
        r.z     = outv[2][SB-1:0];
        r.still = hold_active;
        r.full  = hist_filled;
        return r;
    endfunction

    task automatic cfg_write(input logic [tshd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tshd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            tshd_pkg::REG_OFFSET_X:  cal_off[0] = data[tshd_pkg::OFFSET_W-1:0];
            tshd_pkg::REG_OFFSET_Y:  cal_off[1] = data[tshd_pkg::OFFSET_W-1:0];
            tshd_pkg::REG_OFFSET_Z:  cal_off[2] = data[tshd_pkg::OFFSET_W-1:0];
            tshd_pkg::REG_GAIN_X:    cal_gain[0] = data[tshd_pkg::GAIN_W-1:0];
            tshd_pkg::REG_GAIN_Y:    cal_gain[1] = data[tshd_pkg::GAIN_W-1:0];
            tshd_pkg::REG_GAIN_Z:    cal_gain[2] = data[tshd_pkg::GAIN_W-1:0];
            tshd_pkg::REG_THRESHOLD: cal_thr = data[tshd_pkg::THR_W-1:0];
            tshd_pkg::REG_DEAD_BAND: cal_db = data[tshd_pkg::THR_W-1:0];
            default: ;
        endcase
        hist_filled = 1'b0;
        hold_active = 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_calibration(input logic [23:0] ox, oy, oz, gx, gy, gz, thr, db);
        cfg_write(tshd_pkg::REG_OFFSET_X, ox);
        cfg_write(tshd_pkg::REG_OFFSET_Y, oy);
        cfg_write(tshd_pkg::REG_OFFSET_Z, oz);
        cfg_write(tshd_pkg::REG_GAIN_X, gx);
        cfg_write(tshd_pkg::REG_GAIN_Y, gy);
        cfg_write(tshd_pkg::REG_GAIN_Z, gz);
        cfg_write(tshd_pkg::REG_THRESHOLD, thr);
        cfg_write(tshd_pkg::REG_DEAD_BAND, db);
    endtask

    // Called at a falling edge; returns at the falling edge after the item was taken
    // with the valid still high, or, if an idle gap follows, at its end with the valid low.
    task automatic send_sample(input logic signed [SB-1:0] sx,
                               input logic signed [SB-1:0] sy,
                               input logic signed [SB-1:0] sz);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(DW - 3 * SB){1'b0}}, sz, sy, sx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        dz_out_q.push_back(predict_hold_output(sx, sy, sz));
        @(negedge i_clk);
        gap = src_idle_en ? rand_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        while (dz_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_res want, input t_res got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%s: expected x=%0d y=%0d z=%0d still=%0b full=%0b, ",
                   what, $signed(want.x), $signed(want.y), $signed(want.z), want.still,
                   want.full);
            $display("got x=%0d y=%0d z=%0d still=%0b full=%0b",
                     $signed(got.x), $signed(got.y), $signed(got.z), got.still, got.full);
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        int hold_cnt;
        stall_left = 0;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_axis_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) begin
                    hold_cnt = 0;
                    hold_off_req = 1'b0;
                end
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                stall_left = snk_idle_en ? rand_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.x     = o_m_axis_tdata[SB-1:0];
            got.y     = o_m_axis_tdata[2*SB-1:SB];
            got.z     = o_m_axis_tdata[3*SB-1:2*SB];
            got.still = o_m_axis_tuser[0];
            got.full  = o_m_axis_tuser[1];
            if (dz_out_q.size() == 0) begin
                note_mismatch("unexpected item", '0, got);
            end else begin
                want = dz_out_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.still !== want.still || got.full !== want.full)
                    note_mismatch("output mismatch", want, got);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("three_axis_stability_hold_deadzone_top regression: fail");
        $finish;
    end

    task automatic test_reset_defaults();
        send_sample(24'sd0, 24'sd0, 24'sd0);
        send_sample(SMAX[SB-1:0], SMIN[SB-1:0], -24'sd1);
        send_sample(24'sd101, -24'sd101, 24'sd102);
        send_sample(-24'sd102, -24'sd103, 24'sd0);
        wait_drain();
    endtask

    task automatic test_saturation_rounding();
        cfg_write(tshd_pkg::REG_OFFSET_X, 24'h800000);
        cfg_write(tshd_pkg::REG_GAIN_X, 24'h00FFFF);
        cfg_write(tshd_pkg::REG_OFFSET_Y, 24'h7FFFFF);
        cfg_write(tshd_pkg::REG_GAIN_Y, 24'h00FFFF);
        cfg_write(tshd_pkg::REG_GAIN_Z, 24'h000001);
        cfg_write(tshd_pkg::REG_DEAD_BAND, 24'h000000);
        send_sample(SMAX[SB-1:0], SMIN[SB-1:0], -24'sd1);
        send_sample(24'sd0, 24'sd0, -24'sd16385);
        send_sample(SMIN[SB-1:0], SMAX[SB-1:0], 24'sd16384);
        send_sample(24'sd1, -24'sd1, SMAX[SB-1:0]);
        wait_drain();
    endtask

    task automatic test_hold_release();
        load_calibration(24'd0, 24'd0, 24'd0, 24'd16384, 24'd16384, 24'd16384,
                         24'd128, 24'd102);
        // A range one below the threshold is still; reaching it releases.
        for (int k = 0; k < WIN; k++)
            send_sample((k % 2 != 0) ? 24'sd5127 : 24'sd5000, -24'sd200, 24'sd50);
        send_sample(24'sd5000, -24'sd200, 24'sd50);
        send_sample(24'sd5128, -24'sd200, 24'sd50);
        send_sample(24'sd5000, -24'sd200, 24'sd50);
        wait_drain();
    endtask

    task automatic test_config_clear();
        for (int k = 0; k < 4; k++) send_sample(-24'sd3000, 24'sd90, 24'sd7000);
        wait_drain();
        cfg_write(tshd_pkg::REG_THRESHOLD, 24'd128);
        for (int k = 0; k < 3; k++) send_sample(-24'sd3000, 24'sd90, 24'sd7000);
        wait_drain();
    endtask

    task automatic test_random_phases();
        int n, len, r;
        longint base [3];
        longint amp;
        logic [23:0] rnd;
        logic [23:0] offs [3];
        logic [23:0] gains [3];
        logic [23:0] thr, db;
        logic signed [SB-1:0] s [3];
        for (int p = 0; p < 12; p++) begin
            for (int a = 0; a < 3; a++) begin
                rnd = 24'($urandom());
                r = $urandom_range(0, 3);
                if (p == 1) offs[a] = (a == 1) ? 24'h7FFFFF : 24'h800000;
                else if (r == 0) offs[a] = 24'd0;
                else if (r == 1) offs[a] = clamp_sample(longint'($urandom_range(0, 2000)) - 1000);
                else offs[a] = rnd;
                r = $urandom_range(0, 5);
                rnd = 24'($urandom());
                if (p == 1 || r == 4) gains[a] = {rnd[23:16], 16'hFFFF};
                else if (r == 3) gains[a] = {rnd[23:16], 16'h0000};
                else if (r == 5) gains[a] = rnd;
                else gains[a] = {rnd[23:16], 16'd16384};
            end
            rnd = 24'($urandom());
            r = $urandom_range(0, 3);
            if (p == 0) thr = {rnd[23], 23'd0};
            else if (p == 1) thr = {rnd[23], 23'h7FFFFF};
            else if (r == 0) thr = 24'd128;
            else if (r == 3) thr = rnd;
            else thr = 24'($urandom_range(0, 600));
            r = $urandom_range(0, 3);
            if (p == 0) db = 24'd0;
            else if (p == 1) db = {rnd[0], 23'h7FFFFF};
            else if (r == 0) db = 24'd0;
            else db = 24'($urandom_range(0, 500));
            load_calibration(offs[0], offs[1], offs[2], gains[0], gains[1], gains[2], thr, db);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            n = 0;
            while (n < 100) begin
                if ($urandom_range(0, 4) != 0) begin
                    // Steady run around a base value with bounded jitter.
                    len = $urandom_range(WIN, 2 * WIN + 5);
                    for (int a = 0; a < 3; a++) begin
                        rnd = 24'($urandom());
                        r = $urandom_range(0, 2);
                        if (r == 0) base[a] = longint'($signed(rnd));
                        else if (r == 1) base[a] = longint'($urandom_range(0, 4000)) - 2000;
                        else base[a] = longint'($signed(offs[a]))
                                       + longint'($urandom_range(0, 600)) - 300;
                    end
                    r = $urandom_range(0, 3);
                    if (r == 0) amp = 0;
                    else if (r == 1) amp = longint'($urandom_range(0, 40));
                    else if (r == 2) amp = longint'($urandom_range(0, 200));
                    else amp = longint'($urandom_range(0, 3000));
                    for (int k = 0; k < len; k++) begin
                        for (int a = 0; a < 3; a++)
                            s[a] = clamp_sample(base[a] - amp
                                                + longint'($urandom_range(0, 2 * amp)));
                        send_sample(s[0], s[1], s[2]);
                    end
                    n += len;
                end else begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        for (int a = 0; a < 3; a++) begin
                            rnd = 24'($urandom());
                            s[a] = rnd;
                        end
                        send_sample(s[0], s[1], s[2]);
                    end
                    n += len;
                end
            end
            wait_drain();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_input_backpressure();
        logic [23:0] rnd;
        src_idle_en = 1'b0;
        hold_off_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            rnd = 24'($urandom());
            send_sample(rnd, 24'd1000 + k[3:0], -24'sd77);
        end
        wait_drain();
        src_idle_en = 1'b1;
    endtask

    initial begin
        for (int a = 0; a < 3; a++) begin
            cal_off[a]  = '0;
            cal_gain[a] = tshd_pkg::GAIN_RESET;
            frozen[a]   = 0;
            for (int i = 0; i < WIN; i++) hist[a][i] = 0;
        end
        cal_thr     = tshd_pkg::THR_RESET;
        cal_db      = tshd_pkg::DB_RESET;
        hist_slot   = 0;
        hist_filled = 1'b0;
        hold_active = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_saturation_rounding();
        test_hold_release();
        test_config_clear();
        test_random_phases();
        test_input_backpressure();

        if (mismatch_count == 0) begin
            $display("three_axis_stability_hold_deadzone_top regression: pass");
        end else begin
            $display("three_axis_stability_hold_deadzone_top regression: fail");
        end
        $finish;
    end

endmodule
